[hw/rtl/sfs_pkg.sv]
// Shared types and constants for the x86 stack frame sequencer.
// Used by sfs_alu, sfs_regfile and x86_stack_frame_sequencer_top; depends on nothing.
package sfs_pkg;

    localparam int XLEN = 32;

    // Request action codes.
    localparam logic [2:0] ACT_WRITE_REG = 3'd0;
    localparam logic [2:0] ACT_READ_REG  = 3'd1;
    localparam logic [2:0] ACT_PUSHAD    = 3'd2;
    localparam logic [2:0] ACT_POPAD     = 3'd3;
    localparam logic [2:0] ACT_ENTER     = 3'd4;
    localparam logic [2:0] ACT_MEM_RSP   = 3'd5;

    // Result kinds.
    localparam logic [1:0] KIND_MEM   = 2'd0;
    localparam logic [1:0] KIND_OK    = 2'd1;
    localparam logic [1:0] KIND_FAULT = 2'd2;
    localparam logic [1:0] KIND_REG   = 2'd3;

    // Register numbers.
    localparam logic [2:0] REG_ESP = 3'd4;
    localparam logic [2:0] REG_EBP = 3'd5;
    localparam logic [2:0] REG_EDI = 3'd7;

    localparam logic [XLEN-1:0] STACK_WORD_BYTES = 32'd4;

    // Write port of the register file.
    typedef struct packed {
        logic            en;
        logic [2:0]      idx;
        logic [XLEN-1:0] data;
    } t_rf_wr;

endpackage

[hw/rtl/sfs_alu.sv]
// Shared 32-bit add/subtract unit used for every stack pointer and frame update.
// Depends on sfs_pkg.
module sfs_alu
    import sfs_pkg::*;
(
    input  logic [XLEN-1:0] i_a,
    input  logic [XLEN-1:0] i_b,
    input  logic            i_sub,
    output logic [XLEN-1:0] o_y
);

    always_comb begin
        if (i_sub) begin
            o_y = i_a - i_b;
        end else begin
            o_y = i_a + i_b;
        end
    end

endmodule

[hw/rtl/sfs_regfile.sv]
// Eight general registers with one write port, one indexed read port and
// fixed taps for ESP and EBP. Depends on sfs_pkg.
module sfs_regfile
    import sfs_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_rf_wr          i_wr,
    input  logic [2:0]      i_rd_idx,
    output logic [XLEN-1:0] o_rd_data,
    output logic [XLEN-1:0] o_esp,
    output logic [XLEN-1:0] o_ebp
);

    logic [XLEN-1:0] r_regs [8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_regs[i] <= '0;
            end
        end else if (i_wr.en) begin
            r_regs[i_wr.idx] <= i_wr.data;
        end
    end

    assign o_rd_data = r_regs[i_rd_idx];
    assign o_esp     = r_regs[REG_ESP];
    assign o_ebp     = r_regs[REG_EBP];

endmodule

[hw/rtl/x86_stack_frame_sequencer_top.sv]
// x86 stack frame sequencer: register access, PUSHAD, POPAD and ENTER as 32-bit stack requests.
// Each accepted request holds o_in_stall high until the sequencer is back in ready, as its
// steps share the single adder and the single register file write port; a result passes
// through the pending result register into the output register. The output register lets the
// next request be accepted while a result waits. Synchronous active-low reset clears the
// register file, the sequencer state and the output valid. Needs sfs_pkg, sfs_alu, sfs_regfile.
module x86_stack_frame_sequencer_top
    import sfs_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic [2:0]      i_action,
    input  logic [2:0]      i_reg_index,
    input  logic [31:0]     i_reg_value,
    input  logic [15:0]     i_frame_size,
    input  logic [7:0]      i_nesting_level,
    input  logic [31:0]     i_mem_read_data,
    input  logic            i_mem_fault,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [1:0]      o_result_kind,
    output logic [31:0]     o_mem_address,
    output logic            o_mem_write,
    output logic [31:0]     o_mem_write_data,
    output logic [31:0]     o_fault_address,
    output logic [31:0]     o_reg_data
);

    typedef enum logic [3:0] {
        S_READY,
        S_EXEC,
        S_PUSH_ISSUE,
        S_PUSH_CHECK,
        S_POP_INC,
        S_ENTER_NEXT,
        S_ENTER_FRAME,
        S_ENTER_SIZE,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        OP_IDLE,
        OP_PUSHAD,
        OP_POPAD,
        OP_ENTER
    } t_op;

    typedef struct packed {
        logic [1:0]      kind;
        logic [XLEN-1:0] addr;
        logic            wr;
        logic [XLEN-1:0] wdata;
        logic [XLEN-1:0] faddr;
        logic [XLEN-1:0] rdata;
    } t_result;

    t_state          r_state, n_state;
    t_op             r_busy, n_busy;
    logic [5:0]      r_step, n_step;
    logic [XLEN-1:0] r_saved_sp, n_saved_sp;
    logic [XLEN-1:0] r_frame, n_frame;
    logic [4:0]      r_level, n_level;
    logic [15:0]     r_size, n_size;
    logic [XLEN-1:0] r_push_data, n_push_data;
    // Latched request fields.
    logic [2:0]      r_action, n_action;
    logic [2:0]      r_idx, n_idx;
    logic [XLEN-1:0] r_word, n_word;
    logic [15:0]     r_in_size, n_in_size;
    logic [4:0]      r_in_level, n_in_level;
    logic            r_fault, n_fault;
    // Pending result and output register.
    t_result         r_res, n_res;
    t_result         r_out, n_out;
    logic            r_out_valid, n_out_valid;

    t_rf_wr          rf_wr;
    logic [2:0]      rf_rd_idx;
    logic [XLEN-1:0] rf_rd_data, rf_esp, rf_ebp;
    logic [XLEN-1:0] alu_a, alu_b, alu_y;
    logic            alu_sub;

    logic [5:0]      next_copy;
    logic [5:0]      final_step;
    logic            is_final;
    logic [2:0]      pop_dst;

    sfs_regfile u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (rf_wr),
        .i_rd_idx  (rf_rd_idx),
        .o_rd_data (rf_rd_data),
        .o_esp     (rf_esp),
        .o_ebp     (rf_ebp)
    );

    sfs_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_sub (alu_sub),
        .o_y   (alu_y)
    );

    assign o_in_stall = (r_state != S_READY);
    assign rf_rd_idx  = (r_state == S_PUSH_ISSUE) ? r_step[2:0] : r_idx;

    // The adder works on EBP only when stepping down the frame chain, and adds only for POPAD.
    assign alu_a   = (r_state == S_ENTER_NEXT) ? rf_ebp : rf_esp;
    assign alu_b   = (r_state == S_ENTER_SIZE) ? {16'd0, r_size} : STACK_WORD_BYTES;
    assign alu_sub = (r_state != S_POP_INC);

    // ENTER steps: odd steps are frame-pointer reads, even steps are pushes, and step
    // 2*level-1 is the push of the new frame value.
    assign next_copy  = {1'b0, r_step[5:1]} + 6'd1;
    assign final_step = {r_level - 5'd1, 1'b1};
    assign is_final   = (r_level != 5'd0) && (r_step == final_step);
    assign pop_dst    = REG_EDI - r_step[2:0];

    always_comb begin
        n_state     = r_state;
        n_busy      = r_busy;
        n_step      = r_step;
        n_saved_sp  = r_saved_sp;
        n_frame     = r_frame;
        n_level     = r_level;
        n_size      = r_size;
        n_push_data = r_push_data;
        n_action    = r_action;
        n_idx       = r_idx;
        n_word      = r_word;
        n_in_size   = r_in_size;
        n_in_level  = r_in_level;
        n_fault     = r_fault;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        rf_wr       = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_READY: begin
                if (i_in_valid) begin
                    n_action   = i_action;
                    n_idx      = i_reg_index;
                    n_word     = (i_action == ACT_WRITE_REG) ? i_reg_value : i_mem_read_data;
                    n_in_size  = i_frame_size;
                    n_in_level = i_nesting_level[4:0];
                    n_fault    = i_mem_fault;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res = '0;
                if (r_busy == OP_IDLE) begin
                    case (r_action)
                        ACT_WRITE_REG: begin
                            rf_wr   = '{en: 1'b1, idx: r_idx, data: r_word};
                            n_state = S_READY;
                        end
                        ACT_READ_REG: begin
                            n_res.kind  = KIND_REG;
                            n_res.rdata = rf_rd_data;
                            n_state     = S_EMIT;
                        end
                        ACT_PUSHAD: begin
                            n_busy     = OP_PUSHAD;
                            n_step     = 6'd0;
                            n_saved_sp = rf_esp;
                            n_state    = S_PUSH_ISSUE;
                        end
                        ACT_POPAD: begin
                            n_busy     = OP_POPAD;
                            n_step     = 6'd0;
                            n_res.kind = KIND_MEM;
                            n_res.addr = rf_esp;
                            n_state    = S_EMIT;
                        end
                        ACT_ENTER: begin
                            n_busy      = OP_ENTER;
                            n_step      = 6'd0;
                            n_level     = r_in_level;
                            n_size      = r_in_size;
                            n_push_data = rf_ebp;
                            n_state     = S_PUSH_ISSUE;
                        end
                        default: begin
                            n_state = S_READY;
                        end
                    endcase
                end else if (r_action != ACT_MEM_RSP) begin
                    n_state = S_READY;
                end else begin
                    case (r_busy)
                        OP_PUSHAD: begin
                            n_state = S_PUSH_CHECK;
                        end
                        OP_POPAD: begin
                            if (r_fault) begin
                                n_busy      = OP_IDLE;
                                n_step      = 6'd0;
                                n_res.kind  = KIND_FAULT;
                                n_res.faddr = rf_esp;
                                n_state     = S_EMIT;
                            end else begin
                                // The ESP slot is read but not written back.
                                if (pop_dst != REG_ESP) begin
                                    rf_wr = '{en: 1'b1, idx: pop_dst, data: r_word};
                                end
                                n_state = S_POP_INC;
                            end
                        end
                        default: begin
                            if (is_final || !r_step[0]) begin
                                n_state = S_PUSH_CHECK;
                            end else if (r_fault) begin
                                n_busy      = OP_IDLE;
                                n_step      = 6'd0;
                                n_res.kind  = KIND_FAULT;
                                n_res.faddr = rf_ebp;
                                n_state     = S_EMIT;
                            end else begin
                                n_step      = r_step + 6'd1;
                                n_push_data = r_word;
                                n_state     = S_PUSH_ISSUE;
                            end
                        end
                    endcase
                end
            end
            S_PUSH_ISSUE: begin
                n_res       = '0;
                n_res.kind  = KIND_MEM;
                n_res.addr  = alu_y;
                n_res.wr    = 1'b1;
                if (r_busy == OP_PUSHAD) begin
                    // The ESP slot carries the value from the start of the instruction.
                    n_res.wdata = (r_step[2:0] == REG_ESP) ? r_saved_sp : rf_rd_data;
                end else begin
                    n_res.wdata = r_push_data;
                end
                n_state = S_EMIT;
            end
            S_PUSH_CHECK: begin
                n_res = '0;
                if (r_fault) begin
                    n_busy      = OP_IDLE;
                    n_step      = 6'd0;
                    n_res.kind  = KIND_FAULT;
                    n_res.faddr = alu_y;
                    n_state     = S_EMIT;
                end else begin
                    rf_wr = '{en: 1'b1, idx: REG_ESP, data: alu_y};
                    if (r_busy == OP_PUSHAD) begin
                        if (r_step >= 6'd7) begin
                            n_busy     = OP_IDLE;
                            n_step     = 6'd0;
                            n_res.kind = KIND_OK;
                            n_state    = S_EMIT;
                        end else begin
                            n_step  = r_step + 6'd1;
                            n_state = S_PUSH_ISSUE;
                        end
                    end else if (r_step == 6'd0) begin
                        n_frame = alu_y;
                        n_state = S_ENTER_NEXT;
                    end else if (is_final) begin
                        n_state = S_ENTER_FRAME;
                    end else begin
                        n_state = S_ENTER_NEXT;
                    end
                end
            end
            S_POP_INC: begin
                n_res = '0;
                rf_wr = '{en: 1'b1, idx: REG_ESP, data: alu_y};
                if (r_step >= 6'd7) begin
                    n_busy     = OP_IDLE;
                    n_step     = 6'd0;
                    n_res.kind = KIND_OK;
                end else begin
                    n_step     = r_step + 6'd1;
                    n_res.kind = KIND_MEM;
                    n_res.addr = alu_y;
                end
                n_state = S_EMIT;
            end
            S_ENTER_NEXT: begin
                n_res = '0;
                if (next_copy < {1'b0, r_level}) begin
                    rf_wr      = '{en: 1'b1, idx: REG_EBP, data: alu_y};
                    n_step     = r_step + 6'd1;
                    n_res.kind = KIND_MEM;
                    n_res.addr = alu_y;
                    n_state    = S_EMIT;
                end else if (r_level != 5'd0) begin
                    n_step      = final_step;
                    n_push_data = r_frame;
                    n_state     = S_PUSH_ISSUE;
                end else begin
                    n_state = S_ENTER_FRAME;
                end
            end
            S_ENTER_FRAME: begin
                rf_wr   = '{en: 1'b1, idx: REG_EBP, data: r_frame};
                n_state = S_ENTER_SIZE;
            end
            S_ENTER_SIZE: begin
                rf_wr      = '{en: 1'b1, idx: REG_ESP, data: alu_y};
                n_busy     = OP_IDLE;
                n_step     = 6'd0;
                n_res      = '0;
                n_res.kind = KIND_OK;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_READY;
                end
            end
            default: begin
                n_state = S_READY;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_READY;
            r_busy      <= OP_IDLE;
            r_step      <= '0;
            r_saved_sp  <= '0;
            r_frame     <= '0;
            r_level     <= '0;
            r_size      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_busy      <= n_busy;
            r_step      <= n_step;
            r_saved_sp  <= n_saved_sp;
            r_frame     <= n_frame;
            r_level     <= n_level;
            r_size      <= n_size;
            r_out_valid <= n_out_valid;
        end
        r_push_data <= n_push_data;
        r_action    <= n_action;
        r_idx       <= n_idx;
        r_word      <= n_word;
        r_in_size   <= n_in_size;
        r_in_level  <= n_in_level;
        r_fault     <= n_fault;
        r_res       <= n_res;
        r_out       <= n_out;
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_kind    = r_out.kind;
    assign o_mem_address    = r_out.addr;
    assign o_mem_write      = r_out.wr;
    assign o_mem_write_data = r_out.wdata;
    assign o_fault_address  = r_out.faddr;
    assign o_reg_data       = r_out.rdata;

endmodule
